// ----- rtl/smcp_pkg.sv -----
package smcp_pkg;

   // Frame and counter geometry.
   localparam int FRAME_BITS = 16;
   localparam int WAIT_WIDTH = 24;
   localparam int HALF_WIDTH = 16;
   localparam int RX_BITS    = 8;
   localparam int OP_WIDTH   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int BIT_IDX_W  = $clog2(FRAME_BITS + 1);

   localparam logic [HALF_WIDTH-1:0] HALF_RESET = HALF_WIDTH'(4);

   typedef enum logic [OP_WIDTH-1:0] {
      OP_XFER       = 3'd0,
      OP_CALIB      = 3'd1,
      OP_INIT_WAIT  = 3'd2,
      OP_RESET_WAIT = 3'd3,
      OP_CALIB_WAIT = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_PERIOD = 2'd0,
      CSR_INIT_WAIT   = 2'd1,
      CSR_RESET_WAIT  = 2'd2,
      CSR_CALIB_WAIT  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_X_DATA,
      PH_X_CLK,
      PH_X_TAIL,
      PH_X_END,
      PH_C_MOSI_HI,
      PH_C_CLK_HI,
      PH_C_MOSI_LO,
      PH_C_CLK_LO,
      PH_C_END,
      PH_W_END
   } phase_type;

   // Source of a wait counter load.
   typedef enum logic [2:0] {
      WS_NONE,
      WS_HALF,
      WS_INIT,
      WS_RESET,
      WS_CALIB
   } wait_src_type;

   // What to do with one pin on this tick.
   typedef enum logic [1:0] {
      PIN_HOLD,
      PIN_CLR,
      PIN_SET,
      PIN_MSB
   } pin_cmd_type;

   typedef struct packed {
      wait_src_type wait_load;
      logic         wait_dec;
      logic         frame_load;
      logic         bit_shift;
      pin_cmd_type  cs_cmd;
      pin_cmd_type  clk_cmd;
      pin_cmd_type  mosi_cmd;
   } dp_cmd_type;

   typedef struct packed {
      logic wait_zero;
      logic last_bit;
   } dp_status_type;

endpackage

// ----- rtl/smcp_if.sv -----
interface smcp_req_if;
   import smcp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  start_req;
   logic [OP_WIDTH-1:0]   op;
   logic [FRAME_BITS-1:0] tx_word;
   logic                  miso_level;

   modport source (output valid, start_req, op, tx_word, miso_level, input ready);
   modport sink   (input valid, start_req, op, tx_word, miso_level, output ready);
endinterface

interface smcp_rsp_if;
   import smcp_pkg::*;

   logic               valid;
   logic               ready;
   logic               cs_n;
   logic               sclk;
   logic               mosi;
   logic               busy_res;
   logic               done_res;
   logic [RX_BITS-1:0] rx_byte;

   modport source (output valid, cs_n, sclk, mosi, busy_res, done_res, rx_byte, input ready);
   modport sink   (input valid, cs_n, sclk, mosi, busy_res, done_res, rx_byte, output ready);
endinterface

// ----- rtl/smcp_datapath.sv -----
module smcp_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  smcp_pkg::dp_cmd_type           cmd,
   input  logic [smcp_pkg::FRAME_BITS-1:0] tx_word,
   input  logic                           miso_level,
   input  logic                           csr_we,
   input  logic [smcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [smcp_pkg::WAIT_WIDTH-1:0] csr_wdata,
   output smcp_pkg::dp_status_type        status,
   output logic                           cs_n,
   output logic                           sclk,
   output logic                           mosi,
   output logic [smcp_pkg::RX_BITS-1:0]   rx_byte
);
   import smcp_pkg::*;

   logic [HALF_WIDTH-1:0] half_ff, half_in;
   logic [WAIT_WIDTH-1:0] init_ff, init_in;
   logic [WAIT_WIDTH-1:0] rst_wait_ff, rst_wait_in;
   logic [WAIT_WIDTH-1:0] cal_wait_ff, cal_wait_in;

   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [BIT_IDX_W-1:0]  bit_ff, bit_in;
   logic [FRAME_BITS-1:0] tx_ff, tx_in;
   logic [RX_BITS-1:0]    rx_ff, rx_in;
   logic                  cs_ff, cs_in;
   logic                  clk_ff, clk_in;
   logic                  mosi_ff, mosi_in;
   logic                  msb;

   assign msb = tx_ff[FRAME_BITS-1];

   function automatic logic pin_next(pin_cmd_type c, logic cur, logic m);
      logic r;
      case (c)
         PIN_CLR: r = 1'b0;
         PIN_SET: r = 1'b1;
         PIN_MSB: r = m;
         default: r = cur;
      endcase
      return r;
   endfunction

   // Register file writes.
   always_comb begin
      half_in     = half_ff;
      init_in     = init_ff;
      rst_wait_in = rst_wait_ff;
      cal_wait_in = cal_wait_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_in     = csr_wdata[HALF_WIDTH-1:0];
            CSR_INIT_WAIT:   init_in     = csr_wdata;
            CSR_RESET_WAIT:  rst_wait_in = csr_wdata;
            CSR_CALIB_WAIT:  cal_wait_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      wait_in = wait_ff;
      bit_in  = bit_ff;
      tx_in   = tx_ff;
      rx_in   = rx_ff;
      cs_in   = cs_ff;
      clk_in  = clk_ff;
      mosi_in = mosi_ff;
      if (step) begin
         case (cmd.wait_load)
            WS_HALF:  wait_in = WAIT_WIDTH'(half_ff);
            WS_INIT:  wait_in = init_ff;
            WS_RESET: wait_in = rst_wait_ff;
            WS_CALIB: wait_in = cal_wait_ff;
            default: begin
               if (cmd.wait_dec) begin
                  wait_in = wait_ff - WAIT_WIDTH'(1);
               end
            end
         endcase
         if (cmd.frame_load) begin
            tx_in  = tx_word;
            rx_in  = '0;
            bit_in = '0;
         end else if (cmd.bit_shift) begin
            tx_in  = {tx_ff[FRAME_BITS-2:0], 1'b0};
            rx_in  = {rx_ff[RX_BITS-2:0], miso_level};
            bit_in = bit_ff + BIT_IDX_W'(1);
         end
         cs_in   = pin_next(cmd.cs_cmd, cs_ff, msb);
         clk_in  = pin_next(cmd.clk_cmd, clk_ff, msb);
         mosi_in = pin_next(cmd.mosi_cmd, mosi_ff, msb);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff     <= HALF_RESET;
         init_ff     <= '0;
         rst_wait_ff <= '0;
         cal_wait_ff <= '0;
         wait_ff     <= '0;
         bit_ff      <= '0;
         tx_ff       <= '0;
         rx_ff       <= '0;
         cs_ff       <= 1'b1;
         clk_ff      <= 1'b0;
         mosi_ff     <= 1'b0;
      end else begin
         half_ff     <= half_in;
         init_ff     <= init_in;
         rst_wait_ff <= rst_wait_in;
         cal_wait_ff <= cal_wait_in;
         wait_ff     <= wait_in;
         bit_ff      <= bit_in;
         tx_ff       <= tx_in;
         rx_ff       <= rx_in;
         cs_ff       <= cs_in;
         clk_ff      <= clk_in;
         mosi_ff     <= mosi_in;
      end
   end

   assign status.wait_zero = (wait_ff == '0);
   assign status.last_bit  = (bit_ff == BIT_IDX_W'(FRAME_BITS - 1));

   assign cs_n    = cs_ff;
   assign sclk    = clk_ff;
   assign mosi    = mosi_ff;
   assign rx_byte = rx_ff;

endmodule

// ----- rtl/smcp_ctrl.sv -----
module smcp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          start_req,
   input  logic [smcp_pkg::OP_WIDTH-1:0] op,
   input  smcp_pkg::dp_status_type       status,
   output smcp_pkg::dp_cmd_type          cmd,
   output logic                          busy,
   output logic                          done
);
   import smcp_pkg::*;

   phase_type phase_ff, phase_in;
   logic      done_ff, done_in;
   logic      finish;

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (phase_ff == PH_IDLE) begin
            if (start_req) begin
               case (op)
                  OP_XFER:       phase_in = PH_X_DATA;
                  OP_CALIB:      phase_in = PH_C_MOSI_HI;
                  OP_INIT_WAIT,
                  OP_RESET_WAIT,
                  OP_CALIB_WAIT: phase_in = PH_W_END;
                  default:       phase_in = PH_IDLE;
               endcase
            end
         end else if (status.wait_zero) begin
            case (phase_ff)
               PH_X_DATA:    phase_in = PH_X_CLK;
               PH_X_CLK:     phase_in = status.last_bit ? PH_X_TAIL : PH_X_DATA;
               PH_X_TAIL:    phase_in = PH_X_END;
               PH_C_MOSI_HI: phase_in = PH_C_CLK_HI;
               PH_C_CLK_HI:  phase_in = PH_C_MOSI_LO;
               PH_C_MOSI_LO: phase_in = PH_C_CLK_LO;
               PH_C_CLK_LO:  phase_in = PH_C_END;
               default:      phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // Datapath commands.
   always_comb begin
      cmd.wait_load  = WS_NONE;
      cmd.wait_dec   = 1'b0;
      cmd.frame_load = 1'b0;
      cmd.bit_shift  = 1'b0;
      cmd.cs_cmd     = PIN_HOLD;
      cmd.clk_cmd    = PIN_HOLD;
      cmd.mosi_cmd   = PIN_HOLD;
      finish         = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (start_req) begin
            case (op)
               OP_XFER: begin
                  cmd.cs_cmd     = PIN_CLR;
                  cmd.frame_load = 1'b1;
                  cmd.wait_load  = WS_HALF;
               end
               OP_CALIB: begin
                  cmd.cs_cmd    = PIN_SET;
                  cmd.mosi_cmd  = PIN_CLR;
                  cmd.wait_load = WS_HALF;
               end
               OP_INIT_WAIT:  cmd.wait_load = WS_INIT;
               OP_RESET_WAIT: cmd.wait_load = WS_RESET;
               OP_CALIB_WAIT: cmd.wait_load = WS_CALIB;
               default: ;
            endcase
         end
      end else if (!status.wait_zero) begin
         cmd.wait_dec = 1'b1;
      end else begin
         case (phase_ff)
            PH_X_DATA: begin
               cmd.clk_cmd   = PIN_CLR;
               cmd.mosi_cmd  = PIN_MSB;
               cmd.wait_load = WS_HALF;
            end
            PH_X_CLK: begin
               cmd.bit_shift = 1'b1;
               cmd.clk_cmd   = PIN_SET;
               cmd.wait_load = WS_HALF;
            end
            PH_X_TAIL: begin
               cmd.clk_cmd   = PIN_CLR;
               cmd.mosi_cmd  = PIN_CLR;
               cmd.wait_load = WS_HALF;
            end
            PH_X_END: begin
               cmd.cs_cmd = PIN_SET;
               finish     = 1'b1;
            end
            PH_C_MOSI_HI: begin
               cmd.mosi_cmd  = PIN_SET;
               cmd.wait_load = WS_HALF;
            end
            PH_C_CLK_HI: begin
               cmd.clk_cmd   = PIN_SET;
               cmd.wait_load = WS_HALF;
            end
            PH_C_MOSI_LO: begin
               cmd.mosi_cmd  = PIN_CLR;
               cmd.wait_load = WS_HALF;
            end
            PH_C_CLK_LO: begin
               cmd.clk_cmd   = PIN_CLR;
               cmd.wait_load = WS_HALF;
            end
            default: finish = 1'b1;
         endcase
      end
   end

   assign done_in = step ? finish : done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   assign busy = (phase_ff != PH_IDLE);
   assign done = done_ff;

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> phase_ff == PH_IDLE)
      else $error("done flagged while an operation is still active");

   a_hold_no_step : assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(done_ff))
      else $error("sequencer advanced without an accepted tick");

   a_end_done : assert property (@(posedge clock) disable iff (reset)
      step && status.wait_zero && (phase_ff == PH_X_END || phase_ff == PH_C_END ||
      phase_ff == PH_W_END) |=> done_ff && phase_ff == PH_IDLE)
      else $error("final step of an operation did not signal done");

endmodule

// ----- rtl/spi_master_with_calib_pulse.sv -----
// Channel   Direction  Handshake      Contents
// req_if    in         valid/ready    start_req, op, tx_word, miso_level (one sequencer tick)
// rsp_if    out        valid/ready    cs_n, sclk, mosi, busy_res, done_res, rx_byte
// csr_*     in         csr_we only    csr_index, csr_wdata (no read-back)
//
// Each accepted request transaction is one tick of the pin sequencer; the result
// transaction appears in the next cycle.
// One transaction per cycle is sustained: the result register is refilled in the
// same cycle it is drained, so req_if.ready follows rsp_if.ready when a result waits.
// Reset is synchronous and active high; it puts cs_n high, sclk and mosi low and
// loads half_period_ticks with 4 and the wait counts with 0.
// A stalled result holds every field, and no sequencer state moves without a request.

module spi_master_with_calib_pulse (
   input  logic                            clock,
   input  logic                            reset,
   smcp_req_if.sink                        req_if,
   smcp_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [smcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smcp_pkg::WAIT_WIDTH-1:0] csr_wdata
);
   import smcp_pkg::*;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          step;
   dp_cmd_type    cmd;
   dp_status_type status;

   // The sequencer state itself is the result payload: it only changes when a
   // request is accepted, and that only happens when the result slot is free or
   // being drained in the same cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign step         = req_if.valid && req_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;

   // The controller walks through the action list of each operation.
   smcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .start_req (req_if.start_req),
      .op        (req_if.op),
      .status    (status),
      .cmd       (cmd),
      .busy      (rsp_if.busy_res),
      .done      (rsp_if.done_res)
   );

   // The datapath holds the registers, the wait counter, the shift registers
   // and the pin levels.
   smcp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cmd        (cmd),
      .tx_word    (req_if.tx_word),
      .miso_level (req_if.miso_level),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .cs_n       (rsp_if.cs_n),
      .sclk       (rsp_if.sclk),
      .mosi       (rsp_if.mosi),
      .rx_byte    (rsp_if.rx_byte)
   );

endmodule
